// File: design/ilqm_pkg.sv
// Shared types and operation codes for the indexed linked queue manager.
`default_nettype none

package ilqm_pkg;

    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REM = 2'd2;

    // Control for the entry link memories.
    typedef struct packed {
        logic rd_en;
        logic next_we;
        logic prev_we;
    } t_list_ctl;

endpackage

`default_nettype wire

// File: design/ilqm_list_mem.sv
// Per-entry next and prev link memories, one write and one registered read each.
`default_nettype none

module ilqm_list_mem
    import ilqm_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int ID_W    = $clog2(ENTRIES + 1),
    parameter int EID_W   = $clog2(ENTRIES)
) (
    input  wire logic             i_clk,
    input  wire t_list_ctl        i_ctl,
    input  wire logic [EID_W-1:0] i_rd_addr,
    input  wire logic [EID_W-1:0] i_next_waddr,
    input  wire logic [ID_W-1:0]  i_next_wdata,
    input  wire logic [EID_W-1:0] i_prev_waddr,
    input  wire logic [ID_W-1:0]  i_prev_wdata,
    output logic      [ID_W-1:0]  o_next,
    output logic      [ID_W-1:0]  o_prev
);

    logic [ID_W-1:0] mem_next [ENTRIES];
    logic [ID_W-1:0] mem_prev [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_ctl.next_we) begin
            mem_next[i_next_waddr] <= i_next_wdata;
        end
        if (i_ctl.prev_we) begin
            mem_prev[i_prev_waddr] <= i_prev_wdata;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_next <= mem_next[i_rd_addr];
            o_prev <= mem_prev[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/indexed_linked_queue_manager_unit.sv
// Top level of the indexed linked queue manager.
// ENTRIES+1 queues share one doubly linked list over ENTRIES entries; the id
// ENTRIES stands for "none". Each input beat on the in channel (valid/ready)
// is one operation: enqueue at tail, dequeue head, or remove a given entry.
// Each operation yields exactly one beat on the out channel carrying
// o_popped_id (the dequeued id, or none).
// The result register loads from the LOOK state for enqueue, from LINK for
// remove and from POP2 for dequeue (head read, then a dependent read of the
// head's next link, then two writes to the prev memory, which has a single
// write port); a dequeue of an empty queue or an ignored operation loads from
// LOOK. One operation is in flight at a time and ready drops after each beat,
// so no new beat is taken until the operation before it has finished.
// The output register lets the next operation be accepted while a result
// waits; if the receiver stalls, the sequencer holds in its final step until
// the output register frees up.
// After reset a clearing pass writes none to every head, tail and link
// entry, one index per cycle; ready stays low then.
`default_nettype none

module indexed_linked_queue_manager_unit
    import ilqm_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [MODE_W-1:0]                 i_mode,
    input  wire logic [$clog2(ENTRIES + 1)-1:0]    i_queue_id,
    input  wire logic [$clog2(ENTRIES)-1:0]        i_entry_id,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [$clog2(ENTRIES + 1)-1:0]    o_popped_id
);

    localparam int ID_W  = $clog2(ENTRIES + 1);
    localparam int EID_W = $clog2(ENTRIES);
    localparam logic [ID_W-1:0] NONE = ID_W'(ENTRIES);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_LOOK = 3'd2;
    localparam logic [2:0] ST_POP  = 3'd3;
    localparam logic [2:0] ST_POP2 = 3'd4;
    localparam logic [2:0] ST_LINK = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [ID_W-1:0]   r_clr;
    logic [MODE_W-1:0] r_mode;
    logic [ID_W-1:0]   r_q;
    logic [EID_W-1:0]  r_e;
    logic              r_ok;
    logic              r_out_valid;
    logic [ID_W-1:0]   r_out_id;

    logic [ID_W-1:0] mem_head [ENTRIES + 1];
    logic [ID_W-1:0] mem_tail [ENTRIES + 1];
    logic [ID_W-1:0] r_head_rd;
    logic [ID_W-1:0] r_tail_rd;

    logic            accept;
    logic            slot_free;
    logic            fin;
    logic [ID_W-1:0] result;
    logic [ID_W-1:0] e_ext;
    logic            in_ok;

    logic            head_we, tail_we;
    logic [ID_W-1:0] head_waddr, head_wdata, tail_waddr, tail_wdata;

    t_list_ctl        list_ctl;
    logic [EID_W-1:0] list_rd_addr;
    logic [EID_W-1:0] next_waddr, prev_waddr;
    logic [ID_W-1:0]  next_wdata, prev_wdata;
    logic [ID_W-1:0]  list_next, list_prev;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_popped_id = r_out_id;
    assign e_ext       = ID_W'(r_e);

    assign in_ok = (i_queue_id <= NONE) && (i_mode == MODE_DEQ ||
                   ((i_mode == MODE_ENQ || i_mode == MODE_REM) &&
                    (ID_W'(i_entry_id) < NONE)));

    always_comb begin
        n_state      = r_state;
        fin          = 1'b0;
        result       = NONE;
        head_we      = 1'b0;
        head_waddr   = r_q;
        head_wdata   = NONE;
        tail_we      = 1'b0;
        tail_waddr   = r_q;
        tail_wdata   = NONE;
        list_ctl     = '0;
        list_rd_addr = i_entry_id;
        next_waddr   = r_e;
        next_wdata   = NONE;
        prev_waddr   = r_e;
        prev_wdata   = NONE;
        unique case (r_state)
            ST_CLR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                tail_we    = 1'b1;
                tail_waddr = r_clr;
                next_waddr = r_clr[EID_W-1:0];
                prev_waddr = r_clr[EID_W-1:0];
                if (r_clr != NONE) begin
                    list_ctl.next_we = 1'b1;
                    list_ctl.prev_we = 1'b1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                list_ctl.rd_en = accept;
                if (accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!r_ok) begin
                    fin = 1'b1;
                end else begin
                    case (r_mode)
                        MODE_ENQ: begin
                            fin        = 1'b1;
                            tail_we    = 1'b1;
                            tail_wdata = e_ext;
                            if (r_tail_rd == NONE) begin
                                head_we    = 1'b1;
                                head_wdata = e_ext;
                            end else begin
                                list_ctl.prev_we = 1'b1;
                                prev_wdata       = r_tail_rd;
                                list_ctl.next_we = 1'b1;
                                next_waddr       = r_tail_rd[EID_W-1:0];
                                next_wdata       = e_ext;
                            end
                        end
                        MODE_DEQ: begin
                            if (r_head_rd == NONE) begin
                                fin = 1'b1;
                            end else begin
                                list_ctl.rd_en = 1'b1;
                                list_rd_addr   = r_head_rd[EID_W-1:0];
                                n_state        = ST_POP;
                            end
                        end
                        default: begin
                            // remove: clear own links and fix head/tail first
                            list_ctl.next_we = 1'b1;
                            list_ctl.prev_we = 1'b1;
                            if (r_head_rd == e_ext) begin
                                head_we    = 1'b1;
                                head_wdata = list_next;
                            end
                            if (r_tail_rd == e_ext) begin
                                tail_we    = 1'b1;
                                tail_wdata = list_prev;
                            end
                            n_state = ST_LINK;
                        end
                    endcase
                end
            end
            ST_POP: begin
                list_ctl.next_we = 1'b1;
                next_waddr       = r_head_rd[EID_W-1:0];
                head_we          = 1'b1;
                head_wdata       = list_next;
                if (list_next != NONE) begin
                    list_ctl.prev_we = 1'b1;
                    prev_waddr       = list_next[EID_W-1:0];
                end else begin
                    tail_we = 1'b1;
                end
                n_state = ST_POP2;
            end
            ST_POP2: begin
                fin              = 1'b1;
                result           = r_head_rd;
                list_ctl.prev_we = 1'b1;
                prev_waddr       = r_head_rd[EID_W-1:0];
            end
            ST_LINK: begin
                fin = 1'b1;
                if (list_next != NONE) begin
                    list_ctl.prev_we = 1'b1;
                    prev_waddr       = list_next[EID_W-1:0];
                    prev_wdata       = list_prev;
                end
                if (list_prev != NONE) begin
                    list_ctl.next_we = 1'b1;
                    next_waddr       = list_prev[EID_W-1:0];
                    next_wdata       = list_next;
                end
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
        // final step waits for the output register; rewrites while held are harmless
        if (fin) begin
            n_state = slot_free ? ST_IDLE : r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            mem_head[head_waddr] <= head_wdata;
        end
        if (tail_we) begin
            mem_tail[tail_waddr] <= tail_wdata;
        end
        if (accept) begin
            r_head_rd <= mem_head[i_queue_id];
            r_tail_rd <= mem_tail[i_queue_id];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_q    <= i_queue_id;
            r_e    <= i_entry_id;
            r_ok   <= in_ok;
        end
        if (fin && slot_free) begin
            r_out_id <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR && r_clr != NONE) begin
                r_clr <= r_clr + 1'b1;
            end
            if (fin && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    ilqm_list_mem #(
        .ENTRIES (ENTRIES),
        .ID_W    (ID_W),
        .EID_W   (EID_W)
    ) u_list_mem (
        .i_clk        (i_clk),
        .i_ctl        (list_ctl),
        .i_rd_addr    (list_rd_addr),
        .i_next_waddr (next_waddr),
        .i_next_wdata (next_wdata),
        .i_prev_waddr (prev_waddr),
        .i_prev_wdata (prev_wdata),
        .o_next       (list_next),
        .o_prev       (list_prev)
    );

endmodule

`default_nettype wire

// File: tb/indexed_linked_queue_manager_unit_tb.sv
// Testbench for indexed_linked_queue_manager_unit: directed and random queue ops checked.
`timescale 1ns / 100ps

module indexed_linked_queue_manager_unit_tb;
    import ilqm_pkg::*;

    localparam int ENTRIES = 64;
    localparam int QW      = $clog2(ENTRIES + 1);
    localparam int EW      = $clog2(ENTRIES);
    localparam logic [QW-1:0]     NONE     = QW'(ENTRIES);
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;   // unused code, must do nothing

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [QW-1:0]     queue_id;
        logic [EW-1:0]     entry_id;
        logic              typed;     // popped below is the literal expectation
        logic [QW-1:0]     popped;
    } t_queue_op;

    localparam int N_DIRECTED = 25;
    localparam t_queue_op DIRECTED_OPS [N_DIRECTED] = '{
        '{MODE_DEQ, 7'd0,   6'd0,  1'b1, NONE},   // empty after reset
        '{MODE_ENQ, 7'd0,   6'd0,  1'b1, NONE},
        '{MODE_ENQ, 7'd0,   6'd63, 1'b1, NONE},
        '{MODE_ENQ, 7'd64,  6'd5,  1'b1, NONE},   // top queue
        '{MODE_DEQ, 7'd64,  6'd0,  1'b1, 7'd5},
        '{MODE_DEQ, 7'd64,  6'd63, 1'b1, NONE},
        '{MODE_ENQ, 7'd0,   6'd1,  1'b0, NONE},
        '{MODE_REM, 7'd0,   6'd63, 1'b0, NONE},   // unlink from the middle
        '{MODE_DEQ, 7'd0,   6'd0,  1'b1, 7'd0},
        '{MODE_DEQ, 7'd0,   6'd0,  1'b0, NONE},
        '{MODE_DEQ, 7'd0,   6'd0,  1'b0, NONE},
        '{MODE_NOP, 7'd0,   6'd7,  1'b1, NONE},
        '{MODE_ENQ, 7'd127, 6'd3,  1'b1, NONE},   // queue id out of range
        '{MODE_DEQ, 7'd65,  6'd0,  1'b1, NONE},
        '{MODE_REM, 7'd100, 6'd0,  1'b1, NONE},
        '{MODE_ENQ, 7'd3,   6'd10, 1'b0, NONE},
        '{MODE_ENQ, 7'd3,   6'd11, 1'b0, NONE},
        '{MODE_ENQ, 7'd3,   6'd12, 1'b0, NONE},
        '{MODE_REM, 7'd4,   6'd11, 1'b0, NONE},   // entry lives in another queue
        '{MODE_DEQ, 7'd3,   6'd0,  1'b0, NONE},
        '{MODE_DEQ, 7'd3,   6'd0,  1'b0, NONE},
        '{MODE_ENQ, 7'd5,   6'd20, 1'b0, NONE},
        '{MODE_ENQ, 7'd6,   6'd20, 1'b0, NONE},   // enqueue while still linked
        '{MODE_REM, 7'd5,   6'd20, 1'b0, NONE},
        '{MODE_DEQ, 7'd6,   6'd0,  1'b0, NONE}
    };

    logic              i_clk;
    logic              i_rst_n    = 1'b0;
    logic              i_in_valid = 1'b0;
    logic [MODE_W-1:0] i_mode     = MODE_ENQ;
    logic [QW-1:0]     i_queue_id = '0;
    logic [EW-1:0]     i_entry_id = '0;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [QW-1:0]     o_popped_id;

    // Shadow copy of the list state
    logic [QW-1:0] head_of [0:ENTRIES];
    logic [QW-1:0] tail_of [0:ENTRIES];
    logic [QW-1:0] next_of [0:ENTRIES-1];
    logic [QW-1:0] prev_of [0:ENTRIES-1];
    int            owner   [0:ENTRIES-1];   // queue holding each entry, -1 when free

    logic [QW-1:0] popped_expected [$];
    logic [QW-1:0] want_id;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int mismatches     = 0;

    indexed_linked_queue_manager_unit #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_mode),
        .i_queue_id (i_queue_id),
        .i_entry_id (i_entry_id),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_popped_id(o_popped_id)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("indexed_linked_queue_manager_unit test failed");
        $finish;
    end

    // Applies one op to the shadow lists, returns the id it pops.
    function automatic logic [QW-1:0] apply_queue_op(input logic [MODE_W-1:0] m,
                                                     input logic [QW-1:0] q,
                                                     input logic [EW-1:0] e);
        logic [QW-1:0] h, t, n, p, popped, ev;
        popped = NONE;
        ev     = QW'(e);
        if (q <= ENTRIES) begin
            case (m)
                MODE_ENQ: begin
                    t = tail_of[q];
                    if (t == NONE) begin
                        head_of[q] = ev;
                    end else begin
                        prev_of[e] = t;
                        next_of[t] = ev;
                    end
                    tail_of[q] = ev;
                end
                MODE_DEQ: begin
                    h = head_of[q];
                    if (h != NONE) begin
                        n = next_of[h];
                        if (n != NONE) prev_of[n] = NONE;
                        else tail_of[q] = NONE;
                        next_of[h] = NONE;
                        prev_of[h] = NONE;
                        head_of[q] = n;
                        popped = h;
                    end
                end
                MODE_REM: begin
                    h = head_of[q];
                    t = tail_of[q];
                    n = next_of[e];
                    p = prev_of[e];
                    next_of[e] = NONE;
                    prev_of[e] = NONE;
                    if (n != NONE) prev_of[n] = p;
                    if (p != NONE) next_of[p] = n;
                    if (h == ev) head_of[q] = n;
                    if (t == ev) tail_of[q] = p;
                end
                default: ;
            endcase
        end
        return popped;
    endfunction

    task automatic send_op(input logic [MODE_W-1:0] m, input logic [QW-1:0] q,
                           input logic [EW-1:0] e, input logic typed,
                           input logic [QW-1:0] typed_val);
        logic [QW-1:0] popped;
        logic          taken;
        int            gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_queue_id <= q;
        i_entry_id <= e;
        popped = apply_queue_op(m, q, e);
        popped_expected.push_back(typed ? typed_val : popped);
        if (q <= ENTRIES) begin
            case (m)
                MODE_ENQ: owner[e] = int'(q);
                MODE_DEQ: if (popped != NONE) owner[popped] = -1;
                MODE_REM: owner[e] = -1;
                default: ;
            endcase
        end
        // handshake sampled mid-cycle, beat lands on the next rising edge
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (popped_expected.size() == 0) begin
                $display("%0t: result beat with nothing expected, popped_id %0d",
                         $time, o_popped_id);
                mismatches++;
            end else begin
                want_id = popped_expected.pop_front();
                if (o_popped_id !== want_id) begin
                    $display("%0t: popped_id expected %0d, got %0d",
                             $time, want_id, o_popped_id);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        logic [MODE_W-1:0] rm;
        logic [QW-1:0]     rq;
        logic [EW-1:0]     re;
        int                kind, start, idx, k, ph, n_items;
        logic              found, want_free;

        for (k = 0; k <= ENTRIES; k++) begin
            head_of[k] = NONE;
            tail_of[k] = NONE;
        end
        for (k = 0; k < ENTRIES; k++) begin
            next_of[k] = NONE;
            prev_of[k] = NONE;
            owner[k]   = -1;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++) begin
            send_op(DIRECTED_OPS[k].mode, DIRECTED_OPS[k].queue_id, DIRECTED_OPS[k].entry_id,
                    DIRECTED_OPS[k].typed, DIRECTED_OPS[k].popped);
        end

        // phases: free run, sender gaps, receiver stalls, both, then hold-off pressure
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                3: begin send_idle_pct = 26; recv_stall_pct = 26; end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_requests++;
                end
            endcase
            n_items = (ph == 4) ? 50 : 250;
            repeat (n_items) begin
                if ($urandom_range(99) < 8) begin
                    // noise: anything the fields allow
                    rm = MODE_W'($urandom_range(3));
                    rq = QW'($urandom_range(127));
                    re = EW'($urandom_range(ENTRIES - 1));
                end else begin
                    kind      = $urandom_range(99);
                    want_free = (kind < 45);
                    found     = 1'b0;
                    idx       = 0;
                    start     = $urandom_range(ENTRIES - 1);
                    for (k = 0; k < ENTRIES && !found; k++) begin
                        if ((owner[(start + k) % ENTRIES] < 0) == want_free) begin
                            idx   = (start + k) % ENTRIES;
                            found = 1'b1;
                        end
                    end
                    re = EW'($urandom_range(ENTRIES - 1));
                    if (want_free && found) begin
                        rm = MODE_ENQ;
                        re = EW'(idx);
                        // few queues most of the time so lists grow long
                        rq = ($urandom_range(9) < 7) ? QW'($urandom_range(3))
                                                     : QW'($urandom_range(ENTRIES));
                    end else if (kind >= 80 && found) begin
                        rm = MODE_REM;
                        re = EW'(idx);
                        rq = QW'(owner[idx]);
                    end else begin
                        rm = MODE_DEQ;
                        rq = (found && !want_free) ? QW'(owner[idx])
                                                   : QW'($urandom_range(ENTRIES));
                    end
                end
                send_op(rm, rq, re, 1'b0, NONE);
            end
        end
        i_in_valid <= 1'b0;

        while (popped_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("indexed_linked_queue_manager_unit test passed");
        end else begin
            $display("indexed_linked_queue_manager_unit test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
design/ilqm_pkg.sv
design/ilqm_list_mem.sv
design/indexed_linked_queue_manager_unit.sv
tb/indexed_linked_queue_manager_unit_tb.sv
